[src/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion helpers for the frame receiver RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside of reset.
`define ASSERT_DIS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Same-cycle implication checked outside of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`else

`define ASSERT_DIS(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

[src/ufr_pkg.sv]
// ============================================================================
// ufr_pkg
// Types, codes and constants shared by the frame receiver modules.
// ============================================================================
package ufr_pkg;

  localparam int FRAME_MAX_DEFAULT = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int COUNT_W = 7;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  localparam logic [1:0] CMD_BOOT      = 2'd0;
  localparam logic [1:0] CMD_DISCOVERY = 2'd1;
  localparam logic [1:0] CMD_CONNECT   = 2'd2;

  localparam logic [7:0] START_BYTE      = 8'hAA;
  localparam logic [7:0] EVT_READY_IND   = 8'h30;
  localparam logic [7:0] EVT_LINK_STATUS = 8'h01;
  localparam logic [7:0] EVT_PLAY_STATUS = 8'h1E;

  localparam logic [7:0] LS_STANDBY     = 8'h0F;
  localparam logic [7:0] LS_PAIRING     = 8'h01;
  localparam logic [7:0] LS_PAIR_FAIL   = 8'h04;
  localparam logic [7:0] LS_A2DP_UP     = 8'h06;
  localparam logic [7:0] LS_A2DP_DOWN   = 8'h08;
  localparam logic [7:0] LS_AVRCP_UP    = 8'h0B;
  localparam logic [7:0] LS_AVRCP_DOWN  = 8'h0C;

  localparam logic [7:0] PS_STOPPED     = 8'h00;
  localparam logic [7:0] PS_PLAYING     = 8'h01;
  localparam logic [7:0] PS_PAUSED      = 8'h02;
  localparam logic [7:0] PS_FWD_SEEK    = 8'h03;
  localparam logic [7:0] PS_REW_SEEK    = 8'h04;
  localparam logic [7:0] PS_PAUSED_ALT  = 8'h08;
  localparam logic [7:0] PS_UNKNOWN     = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOISE,
    ST_ACCEPTED,
    ST_CSUM_ERR,
    ST_OVERFLOW,
    ST_LEN_ERR
  } frame_status_t;

  typedef enum logic [2:0] {
    LINK_OFF,
    LINK_BOOTING,
    LINK_READY,
    LINK_SCANNING,
    LINK_CONNECTING,
    LINK_CONNECTED,
    LINK_STREAMING
  } link_mode_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PLAY,
    ACT_PAUSE,
    ACT_STOP,
    ACT_NEXT,
    ACT_PREV
  } play_action_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_READY,
    OP_COMMAND,
    OP_LINK_STATUS,
    OP_PLAY_STATUS
  } back_op_t;

  // One classified word handed from the parser to the link/play stage.
  typedef struct packed {
    frame_status_t status;
    logic [7:0]    evt;
    back_op_t      op;
    logic [7:0]    arg;
  } work_t;

endpackage

[src/ufr_front.sv]
// ============================================================================
// ufr_front
// Frame parser: hunts for the start byte, tracks length and checksum, and
// classifies each incoming word into a work word for the back stage.
// ============================================================================
`include "assert_macros.svh"

module ufr_front
  import ufr_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic [1:0] command_code,
  output work_t      work
);

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(FRAME_MAX);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]        frame_length, frame_length_next;
  logic [7:0]         running_sum, running_sum_next;
  logic [7:0]         captured_event, captured_event_next;
  logic [7:0]         captured_first_payload, captured_first_payload_next;
  logic [7:0]         captured_fourth_payload, captured_fourth_payload_next;
  logic [COUNT_W-1:0] count_inc;
  logic [15:0]        length_now;
  logic [16:0]        frame_total;
  logic               frame_ends;

  assign count_inc = byte_count + COUNT_W'(1);

  // Frame length including the byte being taken in this cycle.
  assign length_now  = (byte_count == COUNT_W'(1)) ? {rx_byte, 8'h00} :
                       (byte_count == COUNT_W'(2)) ? {frame_length[15:8], rx_byte} :
                       frame_length;
  assign frame_total = {1'b0, length_now} + 17'd4;

  always_comb begin
    byte_count_next              = byte_count;
    frame_length_next            = frame_length;
    running_sum_next             = running_sum;
    captured_event_next          = captured_event;
    captured_first_payload_next  = captured_first_payload;
    captured_fourth_payload_next = captured_fourth_payload;
    work = '{status: ST_IDLE, evt: 8'h00, op: OP_NONE, arg: 8'h00};

    if (req_type == REQ_COMMAND) begin
      work.op  = OP_COMMAND;
      work.arg = {6'b0, command_code};
    end else if (byte_count == '0 && rx_byte != START_BYTE) begin
      work.status = ST_NOISE;
    end else if (byte_count >= MAX_COUNT) begin
      byte_count_next   = '0;
      frame_length_next = 16'h0000;
      running_sum_next  = 8'h00;
      work.status       = ST_OVERFLOW;
    end else begin
      // The start byte itself is not part of the checksum.
      running_sum_next = (byte_count == '0) ? 8'h00 : running_sum + rx_byte;
      case (byte_count)
        COUNT_W'(1): frame_length_next = {rx_byte, 8'h00};
        COUNT_W'(2): frame_length_next = {frame_length[15:8], rx_byte};
        COUNT_W'(3): captured_event_next = rx_byte;
        COUNT_W'(4): captured_first_payload_next = rx_byte;
        COUNT_W'(7): captured_fourth_payload_next = rx_byte;
        default: ;
      endcase
      byte_count_next = count_inc;

      if (count_inc >= COUNT_W'(4)) begin
        if (frame_length_next == 16'h0000) begin
          byte_count_next   = '0;
          frame_length_next = 16'h0000;
          running_sum_next  = 8'h00;
          work.status       = ST_LEN_ERR;
        end else if ({{(17 - COUNT_W){1'b0}}, count_inc} >= frame_total) begin
          if (running_sum_next != 8'h00) begin
            work.status = ST_CSUM_ERR;
          end else begin
            work.status = ST_ACCEPTED;
            work.evt    = captured_event_next;
            // Payload length checks: length counts the event id byte.
            case (captured_event_next)
              EVT_READY_IND: begin
                if (frame_length_next >= 16'd2 && captured_first_payload_next == 8'h00) begin
                  work.op = OP_SET_READY;
                end
              end
              EVT_LINK_STATUS: begin
                if (frame_length_next >= 16'd2) begin
                  work.op  = OP_LINK_STATUS;
                  work.arg = captured_first_payload_next;
                end
              end
              EVT_PLAY_STATUS: begin
                if (frame_length_next >= 16'd5) begin
                  work.op  = OP_PLAY_STATUS;
                  work.arg = captured_fourth_payload_next;
                end
              end
              default: ;
            endcase
          end
          byte_count_next   = '0;
          frame_length_next = 16'h0000;
          running_sum_next  = 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count              <= '0;
      frame_length            <= 16'h0000;
      running_sum             <= 8'h00;
      captured_event          <= 8'h00;
      captured_first_payload  <= 8'h00;
      captured_fourth_payload <= 8'h00;
    end else if (accept) begin
      byte_count              <= byte_count_next;
      frame_length            <= frame_length_next;
      running_sum             <= running_sum_next;
      captured_event          <= captured_event_next;
      captured_first_payload  <= captured_first_payload_next;
      captured_fourth_payload <= captured_fourth_payload_next;
    end
  end

  assign frame_ends = accept && work.status != ST_IDLE && work.status != ST_NOISE;

  `ASSERT_DIS(a_count_bound, clk, rst, byte_count <= MAX_COUNT)
  `ASSERT_DIS(a_end_clears, clk, rst, frame_ends |=> (byte_count == '0 && running_sum == 8'h00))

endmodule

[src/ufr_queue.sv]
// ============================================================================
// ufr_queue
// Short FIFO of work words between the parser and the link/play stage.
// ============================================================================
`include "assert_macros.svh"

module ufr_queue
  import ufr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output work_t pop_data,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  work_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_DIS(a_count_bound, clk, rst, count <= FULL_CNT)
  `ASSERT_DIS(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !empty)

endmodule

[src/ufr_back.sv]
// ============================================================================
// ufr_back
// Link state machine and play-status change detector, with the result
// register that drives the output channel.
// ============================================================================
`include "assert_macros.svh"

module ufr_back
  import ufr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       work_valid,
  input  work_t      work,
  output logic       pop,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [2:0] frame_status,
  output logic [7:0] event_code,
  output logic [2:0] link_state,
  output logic [2:0] play_action
);

  link_mode_t    link_mode, link_mode_next;
  logic [7:0]    previous_play_status, previous_play_status_next;
  play_action_t  action;

  frame_status_t res_status;
  logic [7:0]    res_evt;
  link_mode_t    res_link;
  play_action_t  res_action;

  assign pop = work_valid && (!result_valid || !result_stall);

  // Next link state.
  always_comb begin
    link_mode_next = link_mode;
    case (work.op)
      OP_SET_READY: link_mode_next = LINK_READY;
      OP_COMMAND: begin
        case (work.arg[1:0])
          CMD_BOOT:      link_mode_next = LINK_BOOTING;
          CMD_DISCOVERY: link_mode_next = LINK_SCANNING;
          CMD_CONNECT:   link_mode_next = LINK_CONNECTING;
          default: ;
        endcase
      end
      OP_LINK_STATUS: begin
        case (work.arg)
          LS_STANDBY:    link_mode_next = LINK_READY;
          LS_PAIRING:    link_mode_next = LINK_SCANNING;
          LS_PAIR_FAIL:  link_mode_next = LINK_READY;
          LS_A2DP_UP:    link_mode_next = LINK_CONNECTED;
          LS_A2DP_DOWN:  link_mode_next = LINK_READY;
          LS_AVRCP_UP:   link_mode_next = LINK_STREAMING;
          LS_AVRCP_DOWN: begin
            if (link_mode == LINK_STREAMING) begin
              link_mode_next = LINK_CONNECTED;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Play action and remembered play status.
  always_comb begin
    previous_play_status_next = previous_play_status;
    action = ACT_NONE;
    case (work.op)
      OP_LINK_STATUS: begin
        // Losing the audio link forgets the last play status.
        if (work.arg == LS_A2DP_DOWN) begin
          previous_play_status_next = PS_UNKNOWN;
        end
      end
      OP_PLAY_STATUS: begin
        if (work.arg != previous_play_status) begin
          previous_play_status_next = work.arg;
          case (work.arg)
            PS_PLAYING:    action = ACT_PLAY;
            PS_PAUSED:     action = ACT_PAUSE;
            PS_PAUSED_ALT: action = ACT_PAUSE;
            PS_STOPPED:    action = ACT_STOP;
            PS_FWD_SEEK:   action = ACT_NEXT;
            PS_REW_SEEK:   action = ACT_PREV;
            default:       action = ACT_NONE;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode            <= LINK_OFF;
      previous_play_status <= PS_UNKNOWN;
      result_valid         <= 1'b0;
      res_link             <= LINK_OFF;
    end else begin
      if (pop) begin
        link_mode            <= link_mode_next;
        previous_play_status <= previous_play_status_next;
        res_link             <= link_mode_next;
        result_valid         <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_status <= work.status;
      res_evt    <= work.evt;
      res_action <= action;
    end
  end

  assign frame_status = res_status;
  assign event_code   = res_evt;
  assign link_state   = res_link;
  assign play_action  = res_action;

  `ASSERT_IMPLY(a_action_on_accept, clk, rst, result_valid && res_action != ACT_NONE, res_status == ST_ACCEPTED)
  `ASSERT_IMPLY(a_link_tracks, clk, rst, result_valid, res_link == link_mode)

endmodule

[src/uart_event_frame_receiver.sv]
// ============================================================================
// uart_event_frame_receiver
// UART event frame parser with link state and play action tracking.
// ============================================================================
// Takes one word per clock while item_stall is low, either a received UART
// byte or a local command event, and returns exactly one result word for
// each, in order. Frames are 0xAA, a 16-bit big-endian length, the event id
// and payload, and a checksum that makes the sum of all bytes after the start
// byte zero. A word is classified by the parser in the cycle it is accepted
// and enters a two-word queue; unless result_stall holds it, the link/play
// stage takes one queued word per cycle into the result register, for a
// sustained rate of one word per cycle. A result passes through a queue slot
// and then the result register. item_stall rises only when the queue is full,
// which happens only after the result side has held result_stall high.

module uart_event_frame_receiver
  import ufr_pkg::*;
#(
  parameter int FRAME_MAX   = FRAME_MAX_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic [1:0] command_code,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [2:0] frame_status,
  output logic [7:0] event_code,
  output logic [2:0] link_state,
  output logic [2:0] play_action
);

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;
  work_t front_work;
  work_t back_work;

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  ufr_front #(
    .FRAME_MAX(FRAME_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (push),
    .req_type    (req_type),
    .rx_byte     (rx_byte),
    .command_code(command_code),
    .work        (front_work)
  );

  ufr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(front_work),
    .pop      (pop),
    .pop_data (back_work),
    .full     (q_full),
    .empty    (q_empty)
  );

  ufr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .work_valid  (!q_empty),
    .work        (back_work),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .frame_status(frame_status),
    .event_code  (event_code),
    .link_state  (link_state),
    .play_action (play_action)
  );

endmodule
